@@ hdl/vrrl_pkg.sv @@
// ----------------------------------------------------------------------------
// vrrl_pkg
// Shared constants, codes and controller/datapath interface types for the
// variable-length record ring log.
// ----------------------------------------------------------------------------
package vrrl_pkg;

    localparam int BUF_WORDS        = 1024;   // power of two, 256 .. 65536
    localparam int MAX_RECORD_WORDS = 32;
    localparam int WORD_BITS        = 32;

    localparam int IDX_W  = $clog2(BUF_WORDS);
    localparam int LEN_W  = 6;
    localparam int SIZE_W = LEN_W + 2;
    localparam int SEQ_W  = 64;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 3;
    localparam int OUT_W  = 32;

    localparam int IN_DATA_W  = ((LEN_W + OUT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_W + 2 + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_START = 3'd0,
        CMD_APPEND_WORD  = 3'd1,
        CMD_READ_NEXT    = 3'd2,
        CMD_SEEK_FIRST   = 3'd3,
        CMD_SEEK_END     = 3'd4,
        CMD_POLL         = 3'd5
    } cmd_t;

    localparam logic [ST_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [ST_W-1:0] ST_WORD     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_LOST     = 3'd3;
    localparam logic [ST_W-1:0] ST_POLL     = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_RES_RD_OLD,
        OP_RES_RD_ZERO,
        OP_RES_DROP,
        OP_WRAP,
        OP_HDR,
        OP_WORD,
        OP_EMPTY,
        OP_OVERRUN,
        OP_SEEK_FIRST,
        OP_SEEK_END,
        OP_POLL,
        OP_RD_HDR,
        OP_RD_HDR0,
        OP_RD_LEN,
        OP_RD_WORD_ADDR,
        OP_RD_WORD_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             res_done;
        logic             need_wrap;
        logic             mem_zero;
        logic             wtf_zero;
        logic             rd_empty;
        logic             rd_lost;
        logic             rd_last;
        logic             out_free;
    } dp_status_t;

endpackage

@@ hdl/variable_record_ring_log.sv @@
// ----------------------------------------------------------------------------
// variable_record_ring_log
// Word-addressed ring of variable-length records with drop-oldest
// reservation and a single reader cursor.
//
//   channel   dir  tuser          tdata                          tlast
//   s_axis    in   command[2:0]   record_length[5:0],data[37:6]  -
//   m_axis    out  status[2:0]    word_out[31:0],readable[32],   last_word
//                                 lost[33]
//
// Each command is latched and decoded. Append start drops oldest records as
// needed, each through reads of the single-port ring memory, writes a wrap
// marker if needed and then the header. Read next reports empty or overrun,
// else reads the header and then each word with an address and a data step.
// Reset clears all pointers and sequences; ring contents are not cleared.
// A stalled m_axis holds the sequencer before each result.
// ----------------------------------------------------------------------------
module variable_record_ring_log
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [vrrl_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // record_length, data_word
    input  logic [vrrl_pkg::CMD_W-1:0]          s_axis_tuser,   // command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [vrrl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // word_out, readable, lost
    output logic [vrrl_pkg::ST_W-1:0]           m_axis_tuser,   // status
    output logic                                m_axis_tlast
);
    import vrrl_pkg::*;

    dp_cmd_t    dcmd;
    dp_status_t st;
    logic       readable;
    logic       lost;
    logic [OUT_W-1:0] word_out;

    vrrl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .dcmd     (dcmd)
    );

    vrrl_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_cmd       (s_axis_tuser),
        .in_len       (s_axis_tdata[LEN_W-1:0]),
        .in_data      (s_axis_tdata[LEN_W+OUT_W-1:LEN_W]),
        .dcmd         (dcmd),
        .st           (st),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (m_axis_tuser),
        .out_word     (word_out),
        .out_last     (m_axis_tlast),
        .out_readable (readable),
        .out_lost     (lost)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-OUT_W-2){1'b0}}, lost, readable, word_out};

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (dcmd.op == OP_RD_WORD_EMIT || dcmd.op == OP_HDR || dcmd.op == OP_WORD ||
         dcmd.op == OP_POLL) |-> st.out_free)
        else $error("result loaded while output register busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == ST_WORD))
        else $error("last flag on a non-word result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (dcmd.op == OP_LATCH) |-> (s_axis_tvalid && s_axis_tready))
        else $error("input latched without a transaction");
`endif

endmodule

@@ hdl/vrrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// vrrl_ctrl
// Sequencer for the ring log: decodes each command and steps the datapath
// through reservation, append, read and cursor operations.
// ----------------------------------------------------------------------------
module vrrl_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vrrl_pkg::dp_status_t  st,
    output vrrl_pkg::dp_cmd_t     dcmd
);
    import vrrl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RES_CHECK,
        S_RES_M1,
        S_RES_M2,
        S_WRAP,
        S_HDR,
        S_WORD,
        S_READ,
        S_RD_M1,
        S_RD_M2,
        S_RD_ADDR,
        S_RD_DATA,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    op_t    op;

    assign in_ready = (state_reg == S_IDLE);
    assign dcmd.op  = op;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority case (st.cmd)
                    CMD_APPEND_START: state_next = S_RES_CHECK;
                    CMD_APPEND_WORD:  state_next = S_WORD;
                    CMD_READ_NEXT:    state_next = S_READ;
                    CMD_SEEK_FIRST,
                    CMD_SEEK_END,
                    CMD_POLL:         state_next = S_EXEC;
                    default:          state_next = S_IDLE;
                endcase
            end
            S_RES_CHECK:
            begin
                if (st.res_done)
                begin
                    state_next = st.need_wrap ? S_WRAP : S_HDR;
                end
                else
                begin
                    op         = OP_RES_RD_OLD;
                    state_next = S_RES_M1;
                end
            end
            S_RES_M1:
            begin
                if (st.mem_zero)
                begin
                    op         = OP_RES_RD_ZERO;
                    state_next = S_RES_M2;
                end
                else
                begin
                    op         = OP_RES_DROP;
                    state_next = S_RES_CHECK;
                end
            end
            S_RES_M2:
            begin
                op         = OP_RES_DROP;
                state_next = S_RES_CHECK;
            end
            S_WRAP:
            begin
                op         = OP_WRAP;
                state_next = S_HDR;
            end
            S_HDR:
            begin
                if (st.out_free)
                begin
                    op         = OP_HDR;
                    state_next = S_IDLE;
                end
            end
            S_WORD:
            begin
                if (st.wtf_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    op         = OP_WORD;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (st.rd_empty)
                begin
                    if (st.out_free)
                    begin
                        op         = OP_EMPTY;
                        state_next = S_IDLE;
                    end
                end
                else if (st.rd_lost)
                begin
                    if (st.out_free)
                    begin
                        op         = OP_OVERRUN;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    op         = OP_RD_HDR;
                    state_next = S_RD_M1;
                end
            end
            S_RD_M1:
            begin
                if (st.mem_zero)
                begin
                    op         = OP_RD_HDR0;
                    state_next = S_RD_M2;
                end
                else
                begin
                    op         = OP_RD_LEN;
                    state_next = S_RD_ADDR;
                end
            end
            S_RD_M2:
            begin
                op         = OP_RD_LEN;
                state_next = S_RD_ADDR;
            end
            S_RD_ADDR:
            begin
                op         = OP_RD_WORD_ADDR;
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (st.out_free)
                begin
                    op         = OP_RD_WORD_EMIT;
                    state_next = st.rd_last ? S_IDLE : S_RD_ADDR;
                end
            end
            S_EXEC:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                    priority case (st.cmd)
                        CMD_SEEK_FIRST: op = OP_SEEK_FIRST;
                        CMD_SEEK_END:   op = OP_SEEK_END;
                        default:        op = OP_POLL;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/vrrl_dp.sv @@
// ----------------------------------------------------------------------------
// vrrl_dp
// Datapath for the ring log: ring memory, sequence and index registers,
// reservation arithmetic and the result register.
// ----------------------------------------------------------------------------
module vrrl_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [vrrl_pkg::CMD_W-1:0]          in_cmd,
    input  logic [vrrl_pkg::LEN_W-1:0]          in_len,
    input  logic [vrrl_pkg::OUT_W-1:0]          in_data,
    input  vrrl_pkg::dp_cmd_t                   dcmd,
    output vrrl_pkg::dp_status_t                st,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vrrl_pkg::ST_W-1:0]           out_status,
    output logic [vrrl_pkg::OUT_W-1:0]          out_word,
    output logic                                out_last,
    output logic                                out_readable,
    output logic                                out_lost
);
    import vrrl_pkg::*;

    logic [WORD_BITS-1:0] mem [BUF_WORDS];
    logic [WORD_BITS-1:0] mem_rd_reg;
    logic [IDX_W-1:0]     mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_we;
    logic                 mem_re;

    logic [CMD_W-1:0] cmd_reg;
    logic [LEN_W-1:0] len_reg;
    logic [OUT_W-1:0] data_reg;
    logic [SEQ_W-1:0] oldest_seq_reg;
    logic [SEQ_W-1:0] next_seq_reg;
    logic [SEQ_W-1:0] reader_seq_reg;
    logic [IDX_W-1:0] oldest_idx_reg;
    logic [IDX_W-1:0] next_idx_reg;
    logic [IDX_W-1:0] reader_idx_reg;
    logic [IDX_W-1:0] tmp_idx_reg;
    logic [IDX_W-1:0] after_idx_reg;
    logic [LEN_W-1:0] wtf_reg;
    logic [LEN_W-1:0] total_reg;
    logic [LEN_W-1:0] n_reg;
    logic [LEN_W-1:0] k_reg;

    logic                 out_valid_reg;
    logic [ST_W-1:0]      out_status_reg;
    logic [OUT_W-1:0]     out_word_reg;
    logic                 out_last_reg;
    logic                 out_readable_reg;
    logic                 out_lost_reg;

    logic [ST_W-1:0]      out_status_next;
    logic [OUT_W-1:0]     out_word_next;
    logic                 out_last_next;
    logic                 out_readable_next;
    logic                 out_lost_next;

    logic [LEN_W-1:0] len_clamped;
    logic [IDX_W:0]   room;
    logic [IDX_W:0]   tail_room;
    logic [SIZE_W-1:0] size_plus1;
    logic [IDX_W:0]   wrap_sum;
    logic [IDX_W-1:0] advance;
    logic [LEN_W-1:0] n_calc;
    logic [IDX_W-1:0] word_pos;
    logic             load_out;
    logic             rd_pending;

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_word     = out_word_reg;
    assign out_last     = out_last_reg;
    assign out_readable = out_readable_reg;
    assign out_lost     = out_lost_reg;

    always_comb
    begin
        if (in_len == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (in_len > LEN_W'(MAX_RECORD_WORDS))
        begin
            len_clamped = LEN_W'(MAX_RECORD_WORDS);
        end
        else
        begin
            len_clamped = in_len;
        end
    end

    // size of the record plus one guard word
    assign size_plus1 = SIZE_W'(len_reg) + SIZE_W'(2);
    assign tail_room  = (IDX_W+1)'(BUF_WORDS) - {1'b0, next_idx_reg};

    always_comb
    begin
        if (next_idx_reg > oldest_idx_reg)
        begin
            room = ({1'b0, oldest_idx_reg} > tail_room) ? {1'b0, oldest_idx_reg} : tail_room;
        end
        else
        begin
            room = {1'b0, oldest_idx_reg} - {1'b0, next_idx_reg};
        end
    end

    assign wrap_sum = {1'b0, next_idx_reg} + (IDX_W+1)'(size_plus1);
    assign advance  = (mem_rd_reg == '0) ? IDX_W'(1) : mem_rd_reg[IDX_W-1:0];

    always_comb
    begin
        if (mem_rd_reg <= WORD_BITS'(1))
        begin
            n_calc = LEN_W'(1);
        end
        else if (mem_rd_reg - WORD_BITS'(1) > WORD_BITS'(MAX_RECORD_WORDS))
        begin
            n_calc = LEN_W'(MAX_RECORD_WORDS);
        end
        else
        begin
            n_calc = LEN_W'(mem_rd_reg - WORD_BITS'(1));
        end
    end

    assign word_pos = next_idx_reg + IDX_W'(1) + IDX_W'(total_reg - wtf_reg);

    assign rd_pending = (reader_seq_reg < next_seq_reg);

    assign st.cmd       = cmd_reg;
    assign st.res_done  = !(oldest_seq_reg < next_seq_reg) ||
                          (room > (IDX_W+1)'(size_plus1));
    assign st.need_wrap = (wrap_sum >= (IDX_W+1)'(BUF_WORDS));
    assign st.mem_zero  = (mem_rd_reg == '0);
    assign st.wtf_zero  = (wtf_reg == '0);
    assign st.rd_empty  = !rd_pending;
    assign st.rd_lost   = (reader_seq_reg < oldest_seq_reg);
    assign st.rd_last   = (k_reg == n_reg - LEN_W'(1));
    assign st.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        mem_addr  = next_idx_reg;
        mem_wdata = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        case (dcmd.op)
            OP_RES_RD_OLD:
            begin
                mem_addr = oldest_idx_reg;
                mem_re   = 1'b1;
            end
            OP_RES_RD_ZERO, OP_RD_HDR0:
            begin
                mem_addr = '0;
                mem_re   = 1'b1;
            end
            OP_RD_HDR:
            begin
                mem_addr = reader_idx_reg;
                mem_re   = 1'b1;
            end
            OP_RD_WORD_ADDR:
            begin
                mem_addr = tmp_idx_reg + IDX_W'(1) + IDX_W'(k_reg);
                mem_re   = 1'b1;
            end
            OP_WRAP:
            begin
                mem_we = 1'b1;
            end
            OP_HDR:
            begin
                mem_wdata = WORD_BITS'(len_reg) + WORD_BITS'(1);
                mem_we    = 1'b1;
            end
            OP_WORD:
            begin
                mem_addr  = word_pos;
                mem_wdata = WORD_BITS'(data_reg);
                mem_we    = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_addr];
        end
    end

    assign load_out = (dcmd.op == OP_HDR) || (dcmd.op == OP_WORD) ||
                      (dcmd.op == OP_EMPTY) || (dcmd.op == OP_OVERRUN) ||
                      (dcmd.op == OP_SEEK_FIRST) || (dcmd.op == OP_SEEK_END) ||
                      (dcmd.op == OP_POLL) || (dcmd.op == OP_RD_WORD_EMIT);

    always_comb
    begin
        out_status_next   = ST_ACCEPTED;
        out_word_next     = '0;
        out_last_next     = 1'b0;
        out_readable_next = 1'b0;
        out_lost_next     = 1'b0;
        case (dcmd.op)
            OP_EMPTY:   out_status_next = ST_EMPTY;
            OP_OVERRUN: out_status_next = ST_LOST;
            OP_POLL:
            begin
                out_status_next   = ST_POLL;
                out_readable_next = rd_pending;
                out_lost_next     = rd_pending && st.rd_lost;
            end
            OP_RD_WORD_EMIT:
            begin
                out_status_next = ST_WORD;
                out_word_next   = OUT_W'(mem_rd_reg);
                out_last_next   = st.rd_last;
            end
            default:    out_status_next = ST_ACCEPTED;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg   <= out_status_next;
            out_word_reg     <= out_word_next;
            out_last_reg     <= out_last_next;
            out_readable_reg <= out_readable_next;
            out_lost_reg     <= out_lost_next;
        end
        case (dcmd.op)
            OP_LATCH:
            begin
                cmd_reg  <= in_cmd;
                len_reg  <= len_clamped;
                data_reg <= in_data;
            end
            OP_RES_RD_OLD:  tmp_idx_reg <= oldest_idx_reg;
            OP_RES_RD_ZERO: tmp_idx_reg <= '0;
            OP_RD_HDR:      tmp_idx_reg <= reader_idx_reg;
            OP_RD_HDR0:     tmp_idx_reg <= '0;
            OP_RD_LEN:
            begin
                n_reg         <= n_calc;
                k_reg         <= '0;
                after_idx_reg <= tmp_idx_reg + advance;
            end
            OP_RD_WORD_EMIT: k_reg <= k_reg + LEN_W'(1);
            OP_HDR:          total_reg <= len_reg;
            default:         k_reg <= k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            oldest_seq_reg <= '0;
            next_seq_reg   <= '0;
            reader_seq_reg <= '0;
            oldest_idx_reg <= '0;
            next_idx_reg   <= '0;
            reader_idx_reg <= '0;
            wtf_reg        <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (dcmd.op)
                OP_LATCH:
                begin
                    if (in_cmd == CMD_APPEND_START)
                    begin
                        wtf_reg <= '0;
                    end
                end
                OP_RES_DROP:
                begin
                    oldest_idx_reg <= tmp_idx_reg + advance;
                    oldest_seq_reg <= oldest_seq_reg + SEQ_W'(1);
                end
                OP_WRAP:  next_idx_reg <= '0;
                OP_HDR:   wtf_reg <= len_reg;
                OP_WORD:
                begin
                    wtf_reg <= wtf_reg - LEN_W'(1);
                    if (wtf_reg == LEN_W'(1))
                    begin
                        next_idx_reg <= next_idx_reg + IDX_W'(total_reg) + IDX_W'(1);
                        next_seq_reg <= next_seq_reg + SEQ_W'(1);
                    end
                end
                OP_OVERRUN, OP_SEEK_FIRST:
                begin
                    reader_seq_reg <= oldest_seq_reg;
                    reader_idx_reg <= oldest_idx_reg;
                end
                OP_SEEK_END:
                begin
                    reader_seq_reg <= next_seq_reg;
                    reader_idx_reg <= next_idx_reg;
                end
                OP_RD_WORD_EMIT:
                begin
                    if (st.rd_last)
                    begin
                        reader_idx_reg <= after_idx_reg;
                        reader_seq_reg <= reader_seq_reg + SEQ_W'(1);
                    end
                end
                default:  wtf_reg <= wtf_reg;
            endcase
        end
    end

endmodule
